FILE: rtl/core/erdp_pkg.sv
// Package: shared constants, types and the quarter-wave sine coefficients.
package erdp_pkg;

    localparam int OUT_WIDTH = 24;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -24'sh800000;

    // Horner coefficients, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598669;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;

    // sine/cosine pair, Q14, range -16384..16384
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } sincos_t;

endpackage

FILE: rtl/core/euler_rotate_depth_project_unit.sv
// Top level: Euler rotation and depth projection pipeline.
//
// Usage:
//   s_axis: one point per transfer; s_axis_tdata holds x, y, z (signed Q1.14)
//   and the three angles (unsigned turn fractions), packed from bit 0 up.
//   m_axis: one result per point; m_axis_tdata holds left then right, each
//   24-bit signed Q7.16, saturated.
//   depth_we/depth_data write the depth amount (unsigned Q2.14); write it only
//   while the pipeline is empty.
// Throughput: one point per cycle while the output is not stalled.
// Pipeline: 19 register stages (9 in the sine polynomial chain, 10 in the
//   rotation and projection multipliers).
// Reset clears the valid bits and the depth register to zero.
// When m_axis_tready is low while a result waits, every stage holds and
//   s_axis_tready falls with it, so nothing is lost or repeated.
module euler_rotate_depth_project_unit
    import erdp_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // x, y, z, angle_first, angle_second, angle_third from bit 0
    input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // left_value, right_value from bit 0
    output logic [47:0]                             m_axis_tdata,
    input  logic                                    depth_we,
    input  logic [15:0]                             depth_data
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int SC_LAT = 9;
    localparam int PIPE_DEPTH = SC_LAT + 10;

    logic [15:0] depth_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic en;

    // whole pipeline advances unless the last stage holds an untaken result
    assign en = !vld_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            if (depth_we)
            begin
                depth_reg <= depth_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
            end
        end
    end

    // unpack, scale to Q30
    logic signed [33:0] px, py, pz;
    assign px = 34'(signed'(s_axis_tdata[CW-1:0])) <<< (32 - CW);
    assign py = 34'(signed'(s_axis_tdata[2*CW-1:CW])) <<< (32 - CW);
    assign pz = 34'(signed'(s_axis_tdata[3*CW-1:2*CW])) <<< (32 - CW);

    sincos_t sc1, sc2, sc3;
    erdp_sincos #(.ANGLE_WIDTH(AW)) u_sc1 (.clk, .en,
        .angle(s_axis_tdata[3*CW+AW-1:3*CW]), .result(sc1));
    erdp_sincos #(.ANGLE_WIDTH(AW)) u_sc2 (.clk, .en,
        .angle(s_axis_tdata[3*CW+2*AW-1:3*CW+AW]), .result(sc2));
    erdp_sincos #(.ANGLE_WIDTH(AW)) u_sc3 (.clk, .en,
        .angle(s_axis_tdata[3*CW+3*AW-1:3*CW+2*AW]), .result(sc3));

    // coordinates wait for sines
    logic [101:0] xyz_d;
    erdp_x2line #(.WIDTH(102), .DEPTH(SC_LAT)) u_xyz (.clk, .en,
        .din({pz, py, px}), .dout(xyz_d));
    logic signed [33:0] dx, dy, dz;
    assign dx = xyz_d[33:0];
    assign dy = xyz_d[67:34];
    assign dz = xyz_d[101:68];

    // first rotation, stage A: products; stage B: round
    logic signed [49:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic signed [33:0] pz1_reg, pz2_reg, u1_reg, u2_reg;
    sincos_t s2d_reg, s3d_reg, s2e_reg, s3e_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= 50'(dx * sc1.c); a2_reg <= 50'(dy * sc1.s);
            a3_reg <= 50'(dx * sc1.s); a4_reg <= 50'(dy * sc1.c);
            pz1_reg <= dz; s2d_reg <= sc2; s3d_reg <= sc3;
            u1_reg <= 34'((a1_reg - a2_reg + 50'sd8192) >>> 14);
            u2_reg <= 34'((a3_reg + a4_reg + 50'sd8192) >>> 14);
            pz2_reg <= pz1_reg; s2e_reg <= s2d_reg; s3e_reg <= s3d_reg;
        end
    end

    // second rotation
    logic signed [49:0] b1_reg, b2_reg;
    logic signed [33:0] u2b_reg, w1_reg, u2c_reg, pz3_reg, pz4_reg;
    sincos_t s3f_reg, s3g_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= 50'(u1_reg * s2e_reg.c); b2_reg <= 50'(pz2_reg * s2e_reg.s);
            u2b_reg <= u2_reg; s3f_reg <= s3e_reg; pz3_reg <= pz2_reg;
            w1_reg <= 34'((b1_reg - b2_reg + 50'sd8192) >>> 14);
            u2c_reg <= u2b_reg; s3g_reg <= s3f_reg; pz4_reg <= pz3_reg;
        end
    end

    // third rotation, and the depth gain in parallel
    logic signed [49:0] c1_reg, c2_reg, c3_reg, c4_reg;
    logic signed [33:0] rx_reg, ry_reg;
    logic signed [52:0] gp_reg;
    logic signed [29:0] g_reg;
    logic [16:0] m_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= 50'(w1_reg * s3g_reg.c); c2_reg <= 50'(u2c_reg * s3g_reg.s);
            c3_reg <= 50'(w1_reg * s3g_reg.s); c4_reg <= 50'(u2c_reg * s3g_reg.c);
            gp_reg <= 53'($signed({1'b0, depth_reg}) * (pz4_reg + 36'sd10737418240));
            rx_reg <= 34'((c1_reg - c2_reg + 50'sd8192) >>> 14);
            ry_reg <= 34'((c3_reg + c4_reg + 50'sd8192) >>> 14);
            g_reg  <= 30'(((53'sd1 <<< 48) - gp_reg + (53'sd1 <<< 23)) >>> 24);
            m_reg  <= 17'd16384 + {1'b0, depth_reg};
        end
    end

    // projection: times gain, then times (1+depth)
    logic signed [63:0] pl_reg, pr_reg;
    logic signed [40:0] al_reg, ar_reg;
    logic signed [58:0] ql_reg, qr_reg;
    logic [16:0] m2_reg, m3_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl_reg <= 64'(rx_reg * g_reg); pr_reg <= 64'(ry_reg * g_reg);
            m2_reg <= m_reg;
            al_reg <= 41'((pl_reg + (64'sd1 <<< 23)) >>> 24);
            ar_reg <= 41'((pr_reg + (64'sd1 <<< 23)) >>> 24);
            m3_reg <= m2_reg;
            ql_reg <= 59'(al_reg * $signed({1'b0, m3_reg}));
            qr_reg <= 59'(ar_reg * $signed({1'b0, m3_reg}));
        end
    end

    // round and saturate into the output register
    logic signed [58:0] rl, rr;
    logic signed [OUT_WIDTH-1:0] ol_reg, or_reg;
    assign rl = (ql_reg + (59'sd1 <<< 27)) >>> 28;
    assign rr = (qr_reg + (59'sd1 <<< 27)) >>> 28;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ol_reg <= (rl > 59'(OUT_MAX)) ? OUT_MAX :
                      (rl < 59'(OUT_MIN)) ? OUT_MIN : rl[OUT_WIDTH-1:0];
            or_reg <= (rr > 59'(OUT_MAX)) ? OUT_MAX :
                      (rr < 59'(OUT_MIN)) ? OUT_MIN : rr[OUT_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = {or_reg, ol_reg};

`ifndef SYNTHESIS
    // a held result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    // input ready tracks the stall
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
    // accepted item enters the valid chain
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("item lost at entry");
`endif

endmodule

FILE: rtl/core/erdp_sincos.sv
// Pipelined quarter-wave polynomial sine/cosine of one turn-fraction angle.
module erdp_sincos
    import erdp_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [ANGLE_WIDTH-1:0] angle,
    output sincos_t                result
);

    localparam int NST = 8;

    logic [31:0] turn;
    logic [1:0]  quad_in;
    logic [16:0] xs_in;
    logic [16:0] xc_in;

    // align angle to 32-bit turn, keep top 18 bits
    assign turn    = 32'({angle, 32'(0)} >> ANGLE_WIDTH);
    assign quad_in = turn[31:30];
    assign xs_in   = {1'b0, turn[29:14]};
    assign xc_in   = 17'h10000 - {1'b0, turn[29:14]};

    logic [1:0]  quad_reg [NST];
    logic [16:0] xs_reg [NST];
    logic [16:0] xc_reg [NST];
    logic [33:0] x2s_reg [4];
    logic [33:0] x2c_reg [4];
    logic signed [33:0] ps_reg [5];
    logic signed [33:0] pc_reg [5];
    logic [15:0] sa_reg, ca_reg;
    sincos_t     res_reg;

    // stage 0: register input; stage 1: x^2, then x^2 travels with its item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg[0] <= quad_in;
            xs_reg[0]   <= xs_in;
            xc_reg[0]   <= xc_in;
            for (int i = 1; i < NST; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
                xs_reg[i]   <= xs_reg[i-1];
                xc_reg[i]   <= xc_reg[i-1];
            end
            x2s_reg[0] <= 34'((xs_reg[0] * xs_reg[0]) >> 16);
            x2c_reg[0] <= 34'((xc_reg[0] * xc_reg[0]) >> 16);
            for (int i = 1; i < 4; i++)
            begin
                x2s_reg[i] <= x2s_reg[i-1];
                x2c_reg[i] <= x2c_reg[i-1];
            end
        end
    end

    // Horner steps, one multiply per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg[0] <= $signed({2'b0, SIN_C7})
                - 34'(($signed({2'b0, SIN_C9}) * $signed({1'b0, x2s_reg[0]})) >>> 16);
            pc_reg[0] <= $signed({2'b0, SIN_C7})
                - 34'(($signed({2'b0, SIN_C9}) * $signed({1'b0, x2c_reg[0]})) >>> 16);
            ps_reg[1] <= $signed({2'b0, SIN_C5})
                - 34'((64'(ps_reg[0]) * $signed({30'b0, x2s_reg[1]})) >>> 16);
            pc_reg[1] <= $signed({2'b0, SIN_C5})
                - 34'((64'(pc_reg[0]) * $signed({30'b0, x2c_reg[1]})) >>> 16);
            ps_reg[2] <= $signed({2'b0, SIN_C3})
                - 34'((64'(ps_reg[1]) * $signed({30'b0, x2s_reg[2]})) >>> 16);
            pc_reg[2] <= $signed({2'b0, SIN_C3})
                - 34'((64'(pc_reg[1]) * $signed({30'b0, x2c_reg[2]})) >>> 16);
            ps_reg[3] <= $signed({2'b0, SIN_C1})
                - 34'((64'(ps_reg[2]) * $signed({30'b0, x2s_reg[3]})) >>> 16);
            pc_reg[3] <= $signed({2'b0, SIN_C1})
                - 34'((64'(pc_reg[2]) * $signed({30'b0, x2c_reg[3]})) >>> 16);
            ps_reg[4] <= 34'((64'(ps_reg[3]) * $signed({47'b0, xs_reg[5]})) >>> 16);
            pc_reg[4] <= 34'((64'(pc_reg[3]) * $signed({47'b0, xc_reg[5]})) >>> 16);
        end
    end

    // round to Q14 and limit
    logic signed [33:0] rs, rc;
    assign rs = (ps_reg[4] + 34'sd32768) >>> 16;
    assign rc = (pc_reg[4] + 34'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg <= (rs > 34'sd16384) ? 16'd16384 : rs[15:0];
            ca_reg <= (rc > 34'sd16384) ? 16'd16384 : rc[15:0];
        end
    end

    // quadrant symmetry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad_reg[NST-1])
                2'd0:    res_reg <= '{s: $signed(sa_reg),  c: $signed(ca_reg)};
                2'd1:    res_reg <= '{s: $signed(ca_reg),  c: -$signed(sa_reg)};
                2'd2:    res_reg <= '{s: -$signed(sa_reg), c: -$signed(ca_reg)};
                default: res_reg <= '{s: -$signed(ca_reg), c: $signed(sa_reg)};
            endcase
        end
    end

    assign result = res_reg;

endmodule

FILE: rtl/core/erdp_x2line.sv
// Delay line for a bit vector moving alongside the sine pipeline.
module erdp_x2line
    import erdp_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift by one per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

FILE: verif/tb_top.sv
// Testbench for the Euler rotation and depth projection unit.
`timescale 1ns / 100ps

module tb_top;
    import erdp_pkg::*;

    localparam int CW = 16;
    localparam int AW = 16;
    localparam int IN_BITS = ((3*CW+3*AW+7)/8)*8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [15:0] ang3;
        logic [15:0] ang2;
        logic [15:0] ang1;
        logic signed [15:0] pz;
        logic signed [15:0] py;
        logic signed [15:0] px;
    } point_t;

    typedef struct packed {
        logic signed [23:0] right_v;
        logic signed [23:0] left_v;
    } proj_t;

    typedef struct {
        point_t pt;
        bit     has_exp;
        proj_t  exp_v;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic depth_we;
    logic [15:0] depth_data;

    logic [15:0] depth_reg;
    proj_t expected_q[$];
    int errors = 0;
    int row_errors = 0;
    int cycles = 0;
    int results_seen = 0;

    euler_rotate_depth_project_unit #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .depth_we(depth_we), .depth_data(depth_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Round half up: floor(v/2^n + 1/2)
    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n-1))) >>> n;
    endfunction

    function automatic longint qsine(longint x);
        longint x2, p, r;
        x2 = (x * x) >>> 16;
        p = SIN_C9;
        p = longint'(SIN_C7) - ((p * x2) >>> 16);
        p = longint'(SIN_C5) - ((p * x2) >>> 16);
        p = longint'(SIN_C3) - ((p * x2) >>> 16);
        p = longint'(SIN_C1) - ((p * x2) >>> 16);
        r = (((p * x) >>> 16) + (64'sd1 <<< 15)) >>> 16;
        return (r > 16384) ? 16384 : r;
    endfunction

    function automatic void angle_trig(logic [15:0] a, output longint s, output longint c);
        logic [31:0] t;
        longint x, sa, ca;
        t = {a, 16'd0};
        x = longint'(t[29:14]);
        sa = qsine(x);
        ca = qsine(65536 - x);
        case (t[31:30])
            2'd0: begin s = sa;  c = ca;  end
            2'd1: begin s = ca;  c = -sa; end
            2'd2: begin s = -sa; c = -ca; end
            default: begin s = -ca; c = sa; end
        endcase
    endfunction

    function automatic logic signed [23:0] scale_sat(longint v30, longint g24, longint m14);
        longint a, r;
        a = rnd_shift(v30 * g24, 24);
        r = rnd_shift(a * m14, 28);
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function automatic proj_t project_point(point_t p, logic [15:0] depth);
        longint x30, y30, z30, s1, c1, s2, c2, s3, c3, u1, u2, w1, rx, ry, d, g, m;
        proj_t o;
        x30 = longint'(p.px) <<< 16;
        y30 = longint'(p.py) <<< 16;
        z30 = longint'(p.pz) <<< 16;
        angle_trig(p.ang1, s1, c1);
        angle_trig(p.ang2, s2, c2);
        angle_trig(p.ang3, s3, c3);
        u1 = rnd_shift(x30 * c1 - y30 * s1, 14);
        u2 = rnd_shift(x30 * s1 + y30 * c1, 14);
        w1 = rnd_shift(u1 * c2 - z30 * s2, 14);
        rx = rnd_shift(w1 * c3 - u2 * s3, 14);
        ry = rnd_shift(w1 * s3 + u2 * c3, 14);
        d = longint'(depth);
        g = rnd_shift((64'sd1 <<< 48) - d * (z30 + 10 * (64'sd1 <<< 30)), 24);
        m = 16384 + d;
        o.left_v = scale_sat(rx, g, m);
        o.right_v = scale_sat(ry, g, m);
        return o;
    endfunction

    function automatic point_t mk_point(int x, int y, int z, int a1, int a2, int a3);
        point_t p;
        p.px = 16'(x); p.py = 16'(y); p.pz = 16'(z);
        p.ang1 = 16'(a1); p.ang2 = 16'(a2); p.ang3 = 16'(a3);
        return p;
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p = {$urandom, $urandom, $urandom};
        return p;
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: long ready runs, then bursts of random stalls
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Output check against the oldest expected projection
    always @(posedge clk)
    begin
        proj_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                results_seen++;
                if (got.left_v !== want.left_v)
                begin
                    $error("left_value expected %0d actual %0d", want.left_v, got.left_v);
                    errors++;
                end
                if (got.right_v !== want.right_v)
                begin
                    $error("right_value expected %0d actual %0d", want.right_v, got.right_v);
                    errors++;
                end
            end
        end
    end

    // Send one point, with a random gap before it when burst ends
    int burst_left;
    task automatic send_point(point_t p, bit has_exp, proj_t ev);
        proj_t pred;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        pred = project_point(p, depth_reg);
        if (has_exp && pred !== ev)
        begin
            $error("table row mismatch: expected %h predictor %h", ev, pred);
            row_errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_BITS'(p);
        expected_q.push_back(pred);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_depth(logic [15:0] v);
        depth_we <= 1'b1;
        depth_data <= v;
        @(posedge clk);
        depth_we <= 1'b0;
        depth_reg = v;
    endtask

    stim_row_t dir_tab[$];
    logic [15:0] depth_set[5] = '{16'd0, 16'hFFFF, 16'd16384, 16'd8192, 16'd0};

    initial
    begin
        proj_t zero_out, ev;
        point_t p;
        burst_left = 0;
        depth_reg = 16'd0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        depth_we = 1'b0;
        depth_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; zero point gives zero out, identity keeps x at depth 0
        zero_out = '0;
        dir_tab.push_back('{mk_point(0, 0, 0, 0, 0, 0), 1'b1, zero_out});
        ev.left_v = 24'sd65536; ev.right_v = 24'sd0;
        dir_tab.push_back('{mk_point(16384, 0, 0, 0, 0, 0), 1'b1, ev});
        ev.left_v = 24'sd0; ev.right_v = 24'sd65536;
        dir_tab.push_back('{mk_point(0, 16384, 0, 0, 0, 0), 1'b1, ev});
        dir_tab.push_back('{mk_point(32767, 32767, 32767, 0, 0, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(-32768, -32768, -32768, 0, 0, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(-32768, 32767, 0, 65535, 65535, 65535), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(16384, 0, 0, 16384, 0, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(16384, 0, 0, 32768, 0, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(16384, 0, 0, 49152, 0, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(16384, 16384, 16384, 0, 16384, 0), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(16384, 16384, 16384, 0, 0, 49152), 1'b0, zero_out});
        dir_tab.push_back('{mk_point(32767, -32768, 32767, 8191, 40961, 24577), 1'b0,
                           zero_out});
        dir_tab.push_back('{mk_point(1, -1, 1, 1, 3, 16383), 1'b0, zero_out});

        // Each depth phase runs the table then random points
        for (int ph = 0; ph < 5; ph++)
        begin
            set_depth(depth_set[ph]);
            foreach (dir_tab[i])
                send_point(dir_tab[i].pt, (ph == 0) ? dir_tab[i].has_exp : 1'b0,
                           dir_tab[i].exp_v);
            for (int k = 0; k < 80; k++)
            begin
                p = rand_point();
                if ($urandom_range(0, 4) == 0)
                    p.px = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                if ($urandom_range(0, 4) == 0)
                    p.pz = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                send_point(p, 1'b0, zero_out);
            end
            wait_idle();
        end

        $display("Covered %0d projected points over 5 depth settings (0, max, 1.0, 0.5, 0).",
                 results_seen);
        if (errors == 0 && row_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
